// File: hw/rtl/pixel_blend_modes_assert.svh
// Assertion macros used by the pixel blend top level.
`ifndef PIXEL_BLEND_MODES_ASSERT_SVH
`define PIXEL_BLEND_MODES_ASSERT_SVH

// Same-cycle implication, checked only while out of reset.
`define PBM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define PBM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pbm_pkg.sv
// Shared types, constants and the square root table of the pixel blend block.
package pbm_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned OpacW    = 9;
  localparam int unsigned NumLanes = 3;
  localparam int unsigned RootW    = 17;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned InDataW  = 7 * ChanW;
  localparam int unsigned OutDataW = 4 * ChanW;
  localparam int unsigned DivW     = 32;
  localparam int unsigned RecipW   = 25;
  localparam int unsigned PipeLen  = 8;

  localparam logic [OpacW-1:0] OpacOne   = 9'd256;
  localparam logic [OpacW-1:0] OpacReset = 9'd128;
  localparam logic [ChanW-1:0] ChanMax   = 8'd255;
  localparam logic [15:0]      FullSq    = 16'd65025;

  // Reciprocal of 255 scaled by 2^32, rounded down.
  localparam logic [RecipW-1:0] Recip255 = RecipW'((64'd1 << 32) / 64'd255);

  typedef enum logic [ModeW-1:0] {
    ModeNormal     = 3'd0,
    ModeMultiply   = 3'd1,
    ModeScreen     = 3'd2,
    ModeOverlay    = 3'd3,
    ModeSoftLight  = 3'd4,
    ModeDifference = 3'd5
  } blend_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBlendMode    = 2'd0,
    CfgBaseOpacity  = 2'd1,
    CfgUpperOpacity = 2'd2
  } cfg_index_e;

  // Live configuration as seen by the lanes; opacities already limited to 1.0.
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [OpacW-1:0] base_opacity;
    logic [OpacW-1:0] upper_opacity;
  } blend_cfg_t;

  // Result item, blue in the lowest byte.
  typedef struct packed {
    logic [ChanW-1:0] out_alpha;
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
  } pix_out_t;

  typedef logic [RootW-1:0] root_lut_t [256];

  // Integer square root by the digit-pair method, used at elaboration only.
  function automatic logic [RootW-1:0] isqrt_const(logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] bt;
    x  = x_in;
    r  = 64'd0;
    bt = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + bt) begin
        x = x - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r[RootW-1:0];
  endfunction

  // Entry b holds sqrt(b/255) in Q16, rounded down; entry 255 is 65536.
  function automatic root_lut_t build_root_lut();
    root_lut_t lut;
    for (int b = 0; b < 256; b++) begin
      lut[b] = isqrt_const((64'(b) << 32) / 64'd255);
    end
    return lut;
  endfunction

  localparam root_lut_t RootLut = build_root_lut();

endpackage

// File: hw/rtl/pixel_blend_modes.sv
// Top level of the pixel blend block: config registers, three channel lanes, merge stage.
// An accepted input item passes the eight lane stages and then the output register of the
// merge stage before it reaches the output.
// Throughput: one item per cycle; the eight-stage lane pipeline stalls only when
// the two-entry output buffer is full.
// Reset clears the pipeline valids and sets mode normal, both opacities to 128.
`include "pixel_blend_modes_assert.svh"

module pixel_blend_modes (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Fields from bit 0: base_blue, base_green, base_red, upper_blue, upper_green,
  // upper_red, base_alpha.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [pbm_pkg::InDataW-1:0]    s_axis_tdata_i,
  // Fields from bit 0: out_blue, out_green, out_red, out_alpha.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [pbm_pkg::OutDataW-1:0]   m_axis_tdata_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pbm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pbm_pkg::CfgDataW-1:0]   cfg_data_i
);
  import pbm_pkg::*;

  logic [ModeW-1:0]   mode_d;
  logic [ModeW-1:0]   mode_q;
  logic [OpacW-1:0]   bop_d;
  logic [OpacW-1:0]   bop_q;
  logic [OpacW-1:0]   uop_d;
  logic [OpacW-1:0]   uop_q;
  blend_cfg_t         cfg;
  logic               en;
  logic               merge_ready;
  logic [PipeLen-1:0] vld_q;
  logic [ChanW-1:0]   alpha_q [PipeLen];
  logic [ChanW-1:0]   chan [NumLanes];
  pix_out_t           m_pix;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    mode_d = mode_q;
    bop_d  = bop_q;
    uop_d  = uop_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgBlendMode:    mode_d = cfg_data_i[ModeW-1:0];
        CfgBaseOpacity:  bop_d  = cfg_data_i;
        CfgUpperOpacity: uop_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      bop_q  <= OpacReset;
      uop_q  <= OpacReset;
    end else begin
      mode_q <= mode_d;
      bop_q  <= bop_d;
      uop_q  <= uop_d;
    end
  end

  // Opacities above 1.0 act as 1.0.
  assign cfg.mode          = mode_q;
  assign cfg.base_opacity  = (bop_q > OpacOne) ? OpacOne : bop_q;
  assign cfg.upper_opacity = (uop_q > OpacOne) ? OpacOne : uop_q;

  // The whole pipeline moves unless its last item cannot enter the merge stage.
  assign en              = !(vld_q[PipeLen-1] && !merge_ready);
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeLen-2:0], s_axis_tvalid_i};
    end
  end

  // Alpha rides along with the lanes unchanged.
  always_ff @(posedge clk_i) begin
    if (en) begin
      alpha_q[0] <= s_axis_tdata_i[InDataW-1 -: ChanW];
      for (int i = 1; i < PipeLen; i++) begin
        alpha_q[i] <= alpha_q[i-1];
      end
    end
  end

  // One lane per color channel.
  for (genvar gi = 0; gi < NumLanes; gi++) begin : g_lane
    pbm_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .cfg_i   (cfg),
      .base_i  (s_axis_tdata_i[ChanW*gi +: ChanW]),
      .upper_i (s_axis_tdata_i[ChanW*(gi+NumLanes) +: ChanW]),
      .chan_o  (chan[gi])
    );
  end

  pbm_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (vld_q[PipeLen-1]),
    .ready_o         (merge_ready),
    .chan_i          (chan),
    .alpha_i         (alpha_q[PipeLen-1]),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_pix)
  );

  assign m_axis_tdata_o = m_pix;

  // A stalled last-stage item must still be there next cycle.
  `PBM_ASSERT_NXT(a_stall_hold, !en, vld_q[PipeLen-1], "last stage item lost during stall")
  // A full skid entry implies the output register holds an item.
  `PBM_ASSERT_IMP(a_skid_behind_out, !merge_ready, m_axis_tvalid_o, "skid full, output empty")
  // Every accepted item enters the first pipeline stage.
  `PBM_ASSERT_NXT(a_accept_enters, s_axis_tvalid_i && en, vld_q[0], "accepted item lost")

endmodule

// File: hw/rtl/pbm_div255.sv
// Two-stage divide-by-255 unit: reciprocal estimate, then one correction step; passes x through when div_i is low.
module pbm_div255 (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic                      div_i,
  input  logic [pbm_pkg::DivW-1:0]  x_i,
  output logic [pbm_pkg::DivW-1:0]  q_o
);
  import pbm_pkg::*;

  logic [DivW+RecipW-1:0] prod;
  logic [DivW-1:0]        x_q;
  logic                   div_q;
  logic [RecipW-1:0]      q0_q;
  logic [DivW:0]          q0_x255;
  logic [DivW:0]          rem;
  logic [DivW-1:0]        q_d;
  logic [DivW-1:0]        q_q;

  // The estimate is the true quotient or one below it.
  assign prod = (DivW+RecipW)'(x_i) * (DivW+RecipW)'(Recip255);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_i;
      div_q <= div_i;
      q0_q  <= prod[DivW+RecipW-1:DivW];
    end
  end

  // Remainder stays below 510, so one compare fixes the estimate.
  assign q0_x255 = (DivW+1)'({q0_q, 8'd0}) - (DivW+1)'(q0_q);
  assign rem     = (DivW+1)'(x_q) - q0_x255;

  always_comb begin
    if (div_q) begin
      q_d = DivW'(q0_q) + DivW'(rem >= (DivW+1)'(ChanMax));
    end else begin
      q_d = x_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

// File: hw/rtl/pbm_lane.sv
// One color channel lane: blend mode, opacity weighting, rounding and saturation.
module pbm_lane (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  pbm_pkg::blend_cfg_t          cfg_i,
  input  logic [pbm_pkg::ChanW-1:0]    base_i,
  input  logic [pbm_pkg::ChanW-1:0]    upper_i,
  output logic [pbm_pkg::ChanW-1:0]    chan_o
);
  import pbm_pkg::*;

  // How the weighted blend value must still be divided.
  typedef enum logic [1:0] {
    DivNone,
    DivOnce,
    DivTwice,
    DivShift
  } div_cls_e;

  // Stage A signals.
  logic [ChanW-1:0]        nb;
  logic [ChanW-1:0]        nu;
  logic [ChanW-1:0]        k2u;
  logic [RootW-1:0]        root;
  logic signed [25:0]      a_t_d;
  logic [ChanW-1:0]        a_b_q;
  logic [ChanW-1:0]        a_u_q;
  logic [15:0]             a_bu_q;
  logic [15:0]             a_nn_q;
  logic [15:0]             a_p1_q;
  logic signed [25:0]      a_t_q;

  // Stage B signals.
  logic [16:0]             u510;
  logic [16:0]             dark_sum;
  logic [24:0]             dark_num;
  logic signed [8:0]       su_s;
  logic signed [34:0]      st;
  logic [31:0]             bf;
  logic signed [35:0]      zsum;
  logic [31:0]             bright_num;
  div_cls_e                b_cls_d;
  logic [DivW-1:0]         b_x_d;
  div_cls_e                b_cls_q;
  logic [DivW-1:0]         b_x_q;
  logic [15:0]             b_bb_q;

  // Stage C signals.
  logic [DivW+OpacW-1:0]   wprod;
  logic [DivW-1:0]         c_x_d;
  logic [DivW-1:0]         c_x_q;
  logic                    c_div1_q;
  logic                    c_div2_q;
  logic [15:0]             c_bb_q;

  // Divider chain and final stage.
  logic [DivW-1:0]         q1;
  logic [DivW-1:0]         frac_sum;
  logic                    d2_dly_q [2];
  logic [15:0]             bb_dly_q [4];
  logic [17:0]             total;
  logic [ChanW-1:0]        chan_d;
  logic [ChanW-1:0]        chan_q;

  // Stage A: products of the two samples and the soft light root term.
  assign nb    = ChanMax - base_i;
  assign nu    = ChanMax - upper_i;
  assign k2u   = ChanMax - {upper_i[6:0], 1'b0};
  assign root  = RootLut[base_i];
  assign a_t_d = $signed(26'({root, 8'd0}) - 26'(root) - 26'({base_i, 16'd0}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_b_q  <= base_i;
      a_u_q  <= upper_i;
      a_bu_q <= 16'(base_i) * 16'(upper_i);
      a_nn_q <= 16'(nb) * 16'(nu);
      a_p1_q <= 16'(base_i) * 16'(k2u);
      a_t_q  <= a_t_d;
    end
  end

  // Stage B: soft light numerators.
  assign u510       = 17'({a_u_q, 9'd0}) - 17'({a_u_q, 1'b0});
  assign dark_sum   = u510 + 17'(a_p1_q);
  assign dark_num   = 25'(a_b_q) * 25'(dark_sum);
  assign su_s       = $signed({1'b0, a_u_q[6:0], 1'b1});
  assign st         = 35'(su_s) * 35'(a_t_q);
  assign bf         = {16'({a_b_q, 8'd0}) - 16'(a_b_q), 16'd0};
  assign zsum       = 36'($signed({1'b0, bf})) + 36'(st);
  assign bright_num = zsum[35] ? 32'd0 : zsum[31:0];

  // Stage B: blended value as a numerator and its pending divisor.
  always_comb begin
    b_cls_d = DivNone;
    b_x_d   = DivW'(a_u_q);
    case (cfg_i.mode)
      ModeNormal: begin
        b_cls_d = DivNone;
        b_x_d   = DivW'(a_u_q);
      end
      ModeMultiply: begin
        b_cls_d = DivOnce;
        b_x_d   = DivW'(a_bu_q);
      end
      ModeScreen: begin
        b_cls_d = DivOnce;
        b_x_d   = DivW'(FullSq) - DivW'(a_nn_q);
      end
      ModeOverlay: begin
        b_cls_d = DivOnce;
        if (!a_b_q[ChanW-1]) begin
          b_x_d = DivW'({a_bu_q, 1'b0});
        end else begin
          b_x_d = DivW'(FullSq) - DivW'({a_nn_q, 1'b0});
        end
      end
      ModeSoftLight: begin
        if (!a_u_q[ChanW-1]) begin
          b_cls_d = DivTwice;
          b_x_d   = DivW'(dark_num);
        end else begin
          b_cls_d = DivShift;
          b_x_d   = bright_num;
        end
      end
      default: begin
        b_cls_d = DivNone;
        b_x_d   = (a_b_q > a_u_q) ? DivW'(a_b_q - a_u_q) : DivW'(a_u_q - a_b_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_cls_q <= b_cls_d;
      b_x_q   <= b_x_d;
      b_bb_q  <= 16'(a_b_q) * 16'(cfg_i.base_opacity);
    end
  end

  // Stage C: weight by the upper opacity; the root branch drops its Q16 scale.
  assign wprod = (DivW+OpacW)'(b_x_q) * (DivW+OpacW)'(cfg_i.upper_opacity);
  assign c_x_d = (b_cls_q == DivShift) ? DivW'(wprod[DivW+OpacW-1:16]) : wprod[DivW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_x_q    <= c_x_d;
      c_div1_q <= (b_cls_q != DivNone);
      c_div2_q <= (b_cls_q == DivTwice);
      c_bb_q   <= b_bb_q;
    end
  end

  // First division by 255.
  pbm_div255 u_div_first (
    .clk_i (clk_i),
    .en_i  (en_i),
    .div_i (c_div1_q),
    .x_i   (c_x_q),
    .q_o   (q1)
  );

  // Side data delayed alongside the dividers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d2_dly_q[0] <= c_div2_q;
      d2_dly_q[1] <= d2_dly_q[0];
      bb_dly_q[0] <= c_bb_q;
      bb_dly_q[1] <= bb_dly_q[0];
      bb_dly_q[2] <= bb_dly_q[1];
      bb_dly_q[3] <= bb_dly_q[2];
    end
  end

  // Second division by 255, used by the soft light dark branch.
  pbm_div255 u_div_second (
    .clk_i (clk_i),
    .en_i  (en_i),
    .div_i (d2_dly_q[1]),
    .x_i   (q1),
    .q_o   (frac_sum)
  );

  // Final stage: add the base term and a half, scale by 1/256, saturate.
  assign total  = 18'(bb_dly_q[3]) + 18'(OpacReset) + 18'(frac_sum[16:0]);
  assign chan_d = (total[17:16] != 2'd0) ? ChanMax : total[15:8];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

// File: hw/rtl/pbm_merge.sv
// Merge stage: packs the lane results with alpha into an output register and skid buffer.
module pbm_merge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [pbm_pkg::ChanW-1:0]  chan_i [pbm_pkg::NumLanes],
  input  logic [pbm_pkg::ChanW-1:0]  alpha_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output pbm_pkg::pix_out_t          m_axis_tdata_o
);
  import pbm_pkg::*;

  pix_out_t pix;
  logic     out_vld_d;
  logic     out_vld_q;
  pix_out_t out_dat_d;
  pix_out_t out_dat_q;
  logic     skid_vld_d;
  logic     skid_vld_q;
  pix_out_t skid_dat_d;
  pix_out_t skid_dat_q;

  // Combine the three channel lanes and the delayed alpha into one item.
  assign pix.out_blue  = chan_i[0];
  assign pix.out_green = chan_i[1];
  assign pix.out_red   = chan_i[2];
  assign pix.out_alpha = alpha_i;

  assign ready_o = !skid_vld_q;

  // Output register refills from the skid entry first, then from the lanes.
  always_comb begin
    out_vld_d  = out_vld_q;
    out_dat_d  = out_dat_q;
    skid_vld_d = skid_vld_q;
    skid_dat_d = skid_dat_q;
    if (m_axis_tready_i || !out_vld_q) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_dat_d  = skid_dat_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = valid_i;
        out_dat_d = pix;
      end
    end else if (valid_i && !skid_vld_q) begin
      skid_vld_d = 1'b1;
      skid_dat_d = pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_dat_q  <= out_dat_d;
    skid_dat_q <= skid_dat_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_dat_q;

endmodule

// File: tb/sv/pixel_blend_modes_tb.sv
// Self-checking testbench for the pixel blend block, with its own exact-arithmetic predictor.
module pixel_blend_modes_tb;
  import pbm_pkg::*;

  // Input item, base_blue in the lowest byte.
  typedef struct packed {
    logic [ChanW-1:0] base_alpha;
    logic [ChanW-1:0] upper_red;
    logic [ChanW-1:0] upper_green;
    logic [ChanW-1:0] upper_blue;
    logic [ChanW-1:0] base_red;
    logic [ChanW-1:0] base_green;
    logic [ChanW-1:0] base_blue;
  } pix_in_t;

  // Register index that maps to no register; a write to it must change nothing.
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;
  localparam int                 NumModeCodes = 8;
  localparam int                 ItemsPerPhase = 150;
  localparam int                 NumPhases = 11;

  // Exact fixed-point constants: Q16 one, 255^2 and 255^3.
  localparam longint unsigned QOne     = 64'd65536;
  localparam longint unsigned SqFull   = 64'd65025;
  localparam longint unsigned CubeFull = 64'd16581375;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Predictor copy of the configuration registers.
  logic [ModeW-1:0] mode_reg;
  logic [OpacW-1:0] base_opac_reg;
  logic [OpacW-1:0] upper_opac_reg;

  pix_out_t expected_pixels[$];
  int       mismatch_count = 0;
  int       src_idle_pct;
  int       sink_stall_pct;

  pixel_blend_modes i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Global watchdog, far beyond the slowest correct run.
  initial begin
    #400000;
    $display("pixel_blend_modes_tb failed");
    $finish;
  end

  // Floor of sqrt(b/255) in Q16, found by bisection.
  function automatic longint unsigned unit_root_q16(longint unsigned b);
    longint unsigned x;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    x  = (b << 32) / 64'd255;
    lo = 0;
    hi = QOne;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= x) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return lo;
  endfunction

  // One output channel: blended value over 255^3 * 2^16, weighted, rounded, saturated.
  function automatic logic [ChanW-1:0] blend_channel(logic [ChanW-1:0] b8, logic [ChanW-1:0] u8);
    longint unsigned b;
    longint unsigned u;
    longint unsigned nb;
    longint unsigned nu;
    longint unsigned v;
    longint unsigned bo;
    longint unsigned uo;
    longint unsigned n;
    longint unsigned den;
    longint unsigned q;
    longint          t;
    longint          vs;
    b  = b8;
    u  = u8;
    nb = 255 - b;
    nu = 255 - u;
    bo = (base_opac_reg > OpacOne) ? 64'd256 : longint'(base_opac_reg);
    uo = (upper_opac_reg > OpacOne) ? 64'd256 : longint'(upper_opac_reg);
    case (mode_reg)
      ModeNormal:   v = u * SqFull * QOne;
      ModeMultiply: v = b * u * 255 * QOne;
      ModeScreen:   v = (SqFull - nb * nu) * 255 * QOne;
      ModeOverlay: begin
        if (2 * b < 255) begin
          v = 2 * b * u * 255 * QOne;
        end else begin
          v = (SqFull - 2 * nb * nu) * 255 * QOne;
        end
      end
      ModeSoftLight: begin
        if (2 * u < 255) begin
          v = b * (510 * u + b * (255 - 2 * u)) * QOne;
        end else begin
          // Bright branch goes through the square root of the base.
          t  = longint'(255 * unit_root_q16(b)) - longint'(QOne * b);
          vs = longint'(b * SqFull * QOne) + (longint'(2 * u) - 255) * t * 255;
          v  = (vs < 0) ? 64'd0 : longint'(vs);
        end
      end
      // Difference, and the two undefined mode codes that behave like it.
      default: v = ((b > u) ? b - u : u - b) * SqFull * QOne;
    endcase
    n   = b * SqFull * QOne * bo + v * uo;
    den = CubeFull * QOne * 256;
    q   = (n * 255 + den / 2) / den;
    return (q > 255) ? ChanMax : q[ChanW-1:0];
  endfunction

  function automatic pix_out_t blend_pixel(pix_in_t px);
    pix_out_t r;
    r.out_blue  = blend_channel(px.base_blue, px.upper_blue);
    r.out_green = blend_channel(px.base_green, px.upper_green);
    r.out_red   = blend_channel(px.base_red, px.upper_red);
    r.out_alpha = px.base_alpha;
    return r;
  endfunction

  // Channel value biased toward the extremes and the branch thresholds.
  function automatic logic [ChanW-1:0] rand_chan();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return ChanMax;
      2: return 8'(127 + $urandom_range(1));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pix_in_t rand_pixel();
    pix_in_t px;
    px.base_blue   = rand_chan();
    px.base_green  = rand_chan();
    px.base_red    = rand_chan();
    px.upper_blue  = rand_chan();
    px.upper_green = rand_chan();
    px.upper_red   = rand_chan();
    px.base_alpha  = 8'($urandom_range(255));
    return px;
  endfunction

  // Receiver side: random stalls at the configured rate.
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Result checker against the oldest pending expectation.
  always @(posedge clk_i) begin
    pix_out_t got;
    pix_out_t exp_px;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = pix_out_t'(m_axis_tdata_o);
      if (expected_pixels.size() == 0) begin
        $error("result item with no pending expectation: %h", m_axis_tdata_o);
        mismatch_count++;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (got.out_blue !== exp_px.out_blue) begin
          $error("out_blue: expected %0d, got %0d", exp_px.out_blue, got.out_blue);
          mismatch_count++;
        end
        if (got.out_green !== exp_px.out_green) begin
          $error("out_green: expected %0d, got %0d", exp_px.out_green, got.out_green);
          mismatch_count++;
        end
        if (got.out_red !== exp_px.out_red) begin
          $error("out_red: expected %0d, got %0d", exp_px.out_red, got.out_red);
          mismatch_count++;
        end
        if (got.out_alpha !== exp_px.out_alpha) begin
          $error("out_alpha: expected %0d, got %0d", exp_px.out_alpha, got.out_alpha);
          mismatch_count++;
        end
      end
    end
  end

  // Send one item; called at a falling edge and returns at a falling edge.
  task automatic send_pixel(input pix_in_t px);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata_i  <= px;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_pixels = {expected_pixels, blend_pixel(px)};
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every expected result has come, plus the latency.
  task automatic drain_pipeline();
    s_axis_tvalid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (PipeLen + 4) @(negedge clk_i);
  endtask

  // One register write; leaves cfg_valid_i high for a following write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgBlendMode:    mode_reg = data[ModeW-1:0];
      CfgBaseOpacity:  base_opac_reg = data[OpacW-1:0];
      CfgUpperOpacity: upper_opac_reg = data[OpacW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Program all three registers while the block is idle.
  task automatic config_blend(input logic [CfgDataW-1:0] mode_data,
                              input logic [CfgDataW-1:0] base_data,
                              input logic [CfgDataW-1:0] upper_data);
    drain_pipeline();
    write_reg(CfgBlendMode, mode_data);
    write_reg(CfgBaseOpacity, base_data);
    write_reg(CfgUpperOpacity, upper_data);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Reset values: normal mode with both opacities at one half.
  task automatic test_reset_defaults();
    pix_in_t px;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    px = '{default: ChanMax};
    send_pixel(px);
    px = '{base_alpha: 8'h5a, upper_red: 8'd200, upper_green: 8'd1, upper_blue: 8'd128,
           base_red: 8'd10, base_green: 8'd254, base_blue: 8'd127};
    send_pixel(px);
  endtask

  // Every mode code, including the undefined ones, at full opacity on corner pixels.
  task automatic test_mode_corners();
    pix_in_t px;
    for (int m = 0; m < NumModeCodes; m++) begin
      config_blend({6'($urandom_range(63)), 3'(m)}, OpacOne, OpacOne);
      px = '{base_alpha: 8'd0, upper_red: ChanMax, upper_green: ChanMax, upper_blue: ChanMax,
             base_red: 8'd0, base_green: 8'd0, base_blue: 8'd0};
      send_pixel(px);
      px = '{base_alpha: ChanMax, upper_red: 8'd0, upper_green: 8'd0, upper_blue: 8'd0,
             base_red: ChanMax, base_green: ChanMax, base_blue: ChanMax};
      send_pixel(px);
      // Values on both sides of the overlay and soft light thresholds.
      px = '{base_alpha: 8'h81, upper_red: 8'd127, upper_green: 8'd127, upper_blue: 8'd128,
             base_red: 8'd127, base_green: 8'd128, base_blue: 8'd127};
      send_pixel(px);
    end
  endtask

  // Random pixels in phases of different settings and idling patterns.
  task automatic test_random_phases();
    logic [CfgDataW-1:0] mode_data;
    logic [CfgDataW-1:0] base_data;
    logic [CfgDataW-1:0] upper_data;
    for (int p = 0; p < NumPhases; p++) begin
      if (p < NumModeCodes) begin
        mode_data = {6'($urandom_range(63)), 3'(p)};
      end else begin
        mode_data = 9'($urandom_range(511));
      end
      case (p % 5)
        0: base_data = '0;
        1: base_data = OpacOne;
        2: base_data = 9'd511;
        3: base_data = 9'($urandom_range(256));
        default: base_data = 9'($urandom_range(511));
      endcase
      case (p % 3)
        0: upper_data = OpacOne;
        1: upper_data = '0;
        default: upper_data = 9'($urandom_range(511));
      endcase
      config_blend(mode_data, base_data, upper_data);
      // A write to the unused index must leave all registers as they are.
      if (p == 5) begin
        write_reg(CfgIdxUnused, 9'($urandom_range(511)));
        cfg_valid_i <= 1'b0;
        @(negedge clk_i);
      end
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 87; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 87; end
        default: begin src_idle_pct = 6; sink_stall_pct = 6; end
      endcase
      for (int i = 0; i < ItemsPerPhase; i++) begin
        send_pixel(rand_pixel());
      end
    end
  endtask

  // Test sequence.
  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CfgBlendMode;
    cfg_data_i      = '0;
    mode_reg        = ModeNormal;
    base_opac_reg   = OpacReset;
    upper_opac_reg  = OpacReset;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_mode_corners();
    test_random_phases();
    drain_pipeline();
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("pixel_blend_modes_tb passed");
    end else begin
      $display("pixel_blend_modes_tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/pbm_pkg.sv
hw/rtl/pbm_div255.sv
hw/rtl/pbm_lane.sv
hw/rtl/pbm_merge.sv
hw/rtl/pixel_blend_modes.sv
tb/sv/pixel_blend_modes_tb.sv
